@@ rtl/midi_file_stream_parser_defines.svh @@
// ============================================================================
// MIDI file stream parser assertion macros
// Shared macros for the concurrent checks on the parser ports.
// ============================================================================
`ifndef MIDI_FILE_STREAM_PARSER_DEFINES_SVH
`define MIDI_FILE_STREAM_PARSER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MFSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define MFSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mfsp_pkg.sv @@
// ============================================================================
// MIDI file stream parser package
// Shared types, phase codes, result kinds and error codes.
// ============================================================================
package mfsp_pkg;

   localparam int unsigned BpmMax  = 60000000;
   localparam int unsigned BpmW    = 26;
   localparam int unsigned MicroW  = 24;

   // result kinds
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_CHAN   = 3'd1;
   localparam logic [2:0] KIND_TEMPO  = 3'd2;
   localparam logic [2:0] KIND_DONE   = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   // error codes
   localparam logic [1:0] ERR_HDR_LEN   = 2'd0;
   localparam logic [1:0] ERR_NO_TRACKS = 2'd1;
   localparam logic [1:0] ERR_EVENT     = 2'd2;
   localparam logic [1:0] ERR_OVERRUN   = 2'd3;

   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] STAT_META  = 8'hFF;
   localparam logic [7:0] STAT_SYSEX = 8'hF0;
   localparam logic [7:0] STAT_ESC   = 8'hF7;

   typedef enum logic [4:0] {
      PH_HID, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_HSKIP, PH_TID, PH_TLEN,
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_TEMPO,
      PH_SKIP, PH_DONEPEND, PH_DONE, PH_HALT
   } phase_type;

   // controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_OUT    = 4'b1000
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_byte;   // run one parse step on the input byte
      logic div_start;   // load the divider
      logic div_step;    // one quotient bit
      logic div_finish;  // commit tempo and close tempo event
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;    // this step ends a tempo event
      logic has_result;  // this step makes a result
      logic div_last;    // divider on its last bit
   } dp_stat_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] track_index;
      logic [31:0] event_time;
      logic [3:0]  message_type;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [25:0] tempo_bpm;
      logic [15:0] track_count;
      logic [1:0]  error_code;
   } result_type;

   // data bytes per status high nibble
   function automatic logic [1:0] data_bytes_of(input logic [3:0] nib);
      case (nib)
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: data_bytes_of = 2'd2;
         4'hC, 4'hD:                   data_bytes_of = 2'd1;
         default:                      data_bytes_of = 2'd0;
      endcase
   endfunction

endpackage

@@ rtl/mfsp_ctrl.sv @@
// ============================================================================
// MIDI file stream parser controller
// Sequences byte intake, the tempo division and result hand-off.
// ============================================================================
module mfsp_ctrl
   import mfsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   output logic        out_valid,
   input  logic        out_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   ctrl_state_type state_ff, state_in;

   logic take;
   assign in_ready = (state_ff == ST_IDLE) || (state_ff == ST_OUT && out_ready);
   assign take     = in_valid && in_ready;
   assign out_valid = (state_ff == ST_OUT);

   always_comb begin
      cmd = '0;
      cmd.take_byte  = take;
      cmd.div_start  = take && stat.need_div;
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.div_finish = (state_ff == ST_FINISH);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_OUT: begin
            if (take) begin
               if (stat.need_div)        state_in = ST_DIVIDE;
               else if (stat.has_result) state_in = ST_OUT;
               else                      state_in = ST_IDLE;
            end else if (state_ff == ST_OUT && out_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: if (stat.div_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/mfsp_datapath.sv @@
// ============================================================================
// MIDI file stream parser datapath
// Parse state, counters, result register and a bit-serial tempo divider.
// ============================================================================
module mfsp_datapath
   import mfsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  stream_byte,
   input  logic        restart,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output result_type  result
);

   localparam int unsigned QW = BpmW;

   phase_type   phase_ff, phase_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic [33:0] left_ff, left_in;       // signed chunk bytes left
   logic [15:0] total_ff, total_in;
   logic [15:0] track_ff, track_in;
   logic [31:0] atime_ff, atime_in;
   logic [31:0] vlen_ff, vlen_in;
   logic [7:0]  rstat_ff, rstat_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  mkind_ff, mkind_in;
   logic [31:0] pleft_ff, pleft_in;
   logic [23:0] micro_ff, micro_in;
   logic [25:0] tempo_ff, tempo_in;
   result_type  res_ff, res_in;
   logic        emit;
   logic [2:0]  e_kind;
   logic [3:0]  e_mt;
   logic [7:0]  e_d1, e_d2;
   logic [1:0]  e_err;
   logic        need_div;

   // divider
   logic [QW-1:0] quo_ff;
   logic [MicroW:0] rem_ff;
   logic [QW-1:0] dvd_ff;
   logic [4:0]    dcnt_ff;
   logic [MicroW:0] rem_sh;

   // effective state after restart
   phase_type   p0;
   logic [2:0]  f0;
   logic [33:0] l0;
   logic [15:0] tt0, tr0;
   logic [31:0] at0, vl0, pl0;
   logic [7:0]  rs0, hd0, mk0;
   logic [23:0] mi0;
   logic [25:0] tv0;

   logic [33:0] left_dn;
   logic [31:0] vl7;
   logic [1:0]  nb;
   logic [7:0]  rsn;

   always_comb begin
      p0 = restart ? PH_HID : phase_ff;
      f0 = restart ? '0 : fcnt_ff;
      l0 = restart ? '0 : left_ff;
      tt0 = restart ? '0 : total_ff;
      tr0 = restart ? '0 : track_ff;
      at0 = restart ? '0 : atime_ff;
      vl0 = restart ? '0 : vlen_ff;
      rs0 = restart ? '0 : rstat_ff;
      hd0 = restart ? '0 : held_ff;
      mk0 = restart ? '0 : mkind_ff;
      pl0 = restart ? '0 : pleft_ff;
      mi0 = restart ? '0 : micro_ff;
      tv0 = restart ? 26'd120 : tempo_ff;
   end

   // saturating count down to -2^32
   assign left_dn = ($signed(l0) > -$signed({2'b01, 32'd0})) ? l0 - 34'd1 : l0;
   assign vl7 = {vl0[24:0], 7'd0} + {25'd0, stream_byte[6:0]};

   // one parse step
   always_comb begin
      phase_in = p0; fcnt_in = f0; left_in = l0; total_in = tt0; track_in = tr0;
      atime_in = at0; vlen_in = vl0; rstat_in = rs0; held_in = hd0; mkind_in = mk0;
      pleft_in = pl0; micro_in = mi0; tempo_in = tv0;
      emit = 1'b0; e_kind = KIND_HEADER; e_mt = '0; e_d1 = '0; e_d2 = '0;
      e_err = ERR_HDR_LEN; need_div = 1'b0; nb = '0; rsn = rs0;
      begin : step
         logic ev_end;
         logic chan;
         ev_end = 1'b0; chan = 1'b0;
         case (p0)
            PH_HID, PH_TID: begin
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd3) begin
                  fcnt_in = '0; vlen_in = '0;
                  phase_in = (p0 == PH_HID) ? PH_HLEN : PH_TLEN;
               end
            end
            PH_HLEN: begin
               vlen_in = {vl0[23:0], stream_byte};
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd3) begin fcnt_in = '0; phase_in = PH_HFMT; end
            end
            PH_HFMT: begin
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd1) begin fcnt_in = '0; phase_in = PH_HNTRK; end
            end
            PH_HNTRK: begin
               total_in = {tt0[7:0], stream_byte};
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd1) begin fcnt_in = '0; phase_in = PH_HDIV; end
            end
            PH_HDIV: begin
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd1) begin
                  fcnt_in = '0;
                  if (vl0[31]) begin
                     phase_in = PH_HALT; emit = 1'b1; e_kind = KIND_ERROR;
                     e_err = ERR_HDR_LEN;
                  end else if (tt0 == '0) begin
                     phase_in = PH_HALT; emit = 1'b1; e_kind = KIND_ERROR;
                     e_err = ERR_NO_TRACKS;
                  end else begin
                     left_in = {2'b00, vl0} - 34'd6;
                     phase_in = ($signed(left_in) > 0) ? PH_HSKIP : PH_TID;
                     emit = 1'b1; e_kind = KIND_HEADER;
                  end
               end
            end
            PH_HSKIP: begin
               left_in = left_dn;
               if ($signed(left_dn) <= 0) begin fcnt_in = '0; phase_in = PH_TID; end
            end
            PH_TLEN: begin
               vlen_in = {vl0[23:0], stream_byte};
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd3) begin
                  fcnt_in = '0;
                  left_in = {{2{vlen_in[31]}}, vlen_in};
                  atime_in = '0; rstat_in = '0;
                  ev_end = 1'b1;
               end
            end
            PH_DELTA: begin
               left_in = left_dn;
               vlen_in = vl7;
               if (!stream_byte[7]) begin
                  atime_in = at0 + vl7; phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               left_in = left_dn;
               if (stream_byte[7]) rsn = stream_byte;
               rstat_in = rsn;
               nb = data_bytes_of(rsn[7:4]);
               if (nb == 2'd0) begin
                  if (rsn == STAT_META) phase_in = PH_MTYPE;
                  else if (rsn == STAT_SYSEX || rsn == STAT_ESC) begin
                     mkind_in = rsn; vlen_in = '0; phase_in = PH_MLEN;
                  end else begin
                     phase_in = PH_HALT; emit = 1'b1; e_kind = KIND_ERROR;
                     e_err = ERR_EVENT;
                  end
               end else if (stream_byte[7]) phase_in = PH_DATA1;
               else begin
                  held_in = stream_byte;
                  if (nb == 2'd2) phase_in = PH_DATA2;
                  else begin chan = 1'b1; e_d1 = stream_byte; end
               end
            end
            PH_DATA1: begin
               left_in = left_dn;
               held_in = stream_byte;
               if (data_bytes_of(rs0[7:4]) == 2'd2) phase_in = PH_DATA2;
               else begin chan = 1'b1; e_d1 = stream_byte; end
            end
            PH_DATA2: begin
               left_in = left_dn;
               chan = 1'b1; e_d1 = hd0; e_d2 = stream_byte;
            end
            PH_MTYPE: begin
               left_in = left_dn;
               mkind_in = stream_byte; vlen_in = '0; phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               left_in = left_dn;
               vlen_in = vl7;
               if (!stream_byte[7]) begin
                  if ($signed({2'b00, vl7}) > $signed(left_dn)) begin
                     phase_in = PH_HALT; emit = 1'b1; e_kind = KIND_ERROR;
                     e_err = ERR_OVERRUN;
                  end else if (mk0 == META_TEMPO) begin
                     fcnt_in = '0; micro_in = '0; phase_in = PH_TEMPO;
                  end else begin
                     pleft_in = vl7;
                     if (vl7 != '0) phase_in = PH_SKIP;
                     else ev_end = 1'b1;
                  end
               end
            end
            PH_TEMPO: begin
               left_in = left_dn;
               micro_in = {mi0[15:0], stream_byte};
               fcnt_in = f0 + 3'd1;
               if (f0 == 3'd2) begin
                  // finished by the divider sequence
                  fcnt_in = '0; need_div = 1'b1;
               end
            end
            PH_SKIP: begin
               left_in = left_dn;
               pleft_in = pl0 - 32'd1;
               if (pleft_in == '0) ev_end = 1'b1;
            end
            PH_DONEPEND: begin
               phase_in = PH_DONE; emit = 1'b1; e_kind = KIND_DONE;
            end
            default: ;
         endcase
         if (chan) begin
            emit = 1'b1; e_kind = KIND_CHAN; e_mt = rsn[7:4];
            if (p0 != PH_STATUS) e_mt = rs0[7:4];
            ev_end = 1'b1;
         end
         // end of event
         if (ev_end) begin
            if ($signed(left_in) > 0) begin
               phase_in = PH_DELTA; vlen_in = '0;
            end else begin
               track_in = tr0 + 16'd1; fcnt_in = '0;
               if (track_in == tt0) begin
                  if (emit) phase_in = PH_DONEPEND;
                  else begin phase_in = PH_DONE; emit = 1'b1; e_kind = KIND_DONE; end
               end else phase_in = PH_TID;
            end
         end
      end
   end

   always_comb begin
      res_in = '0;
      res_in.kind         = e_kind;
      res_in.track_index  = (e_kind == KIND_DONE) ? track_in : tr0;
      res_in.event_time   = (e_kind == KIND_HEADER) ? '0 : atime_in;
      res_in.message_type = e_mt;
      res_in.data_one     = e_d1;
      res_in.data_two     = e_d2;
      res_in.tempo_bpm    = tv0;
      res_in.track_count  = total_in;
      res_in.error_code   = (e_kind == KIND_ERROR) ? e_err : ERR_HDR_LEN;
   end

   assign stat.need_div   = need_div;
   assign stat.has_result = emit;
   assign stat.div_last   = (dcnt_ff == 5'd0);

   // restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff[MicroW-1:0], dvd_ff[QW-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff  <= QW'(BpmMax);
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= 5'(QW - 1);
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[QW-2:0], 1'b0};
         if (rem_sh >= {1'b0, micro_ff}) begin
            rem_ff <= rem_sh - {1'b0, micro_ff};
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HID; fcnt_ff <= '0; left_ff <= '0; total_ff <= '0;
         track_ff <= '0; atime_ff <= '0; vlen_ff <= '0; rstat_ff <= '0;
         held_ff <= '0; mkind_ff <= '0; pleft_ff <= '0; micro_ff <= '0;
         tempo_ff <= 26'd120;
      end else if (cmd.take_byte) begin
         phase_ff <= phase_in; fcnt_ff <= fcnt_in; left_ff <= left_in;
         total_ff <= total_in; track_ff <= track_in; atime_ff <= atime_in;
         vlen_ff <= vlen_in; rstat_ff <= rstat_in; held_ff <= held_in;
         mkind_ff <= mkind_in; pleft_ff <= pleft_in; micro_ff <= micro_in;
         tempo_ff <= tempo_in;
      end else if (cmd.div_finish) begin
         // close the tempo event with the new tempo
         begin : fin
            logic [25:0] tnew;
            tnew = (micro_ff == '0) ? QW'(BpmMax) : quo_ff;
            tempo_ff <= tnew;
            if ($signed(left_ff) > 0) begin
               phase_ff <= PH_DELTA; vlen_ff <= '0;
            end else begin
               track_ff <= track_ff + 16'd1; fcnt_ff <= '0;
               phase_ff <= ((track_ff + 16'd1) == total_ff) ? PH_DONEPEND : PH_TID;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.take_byte) res_ff <= res_in;
      else if (cmd.div_finish) begin
         res_ff <= '{kind: KIND_TEMPO, track_index: track_ff, event_time: atime_ff,
                     message_type: 4'd0, data_one: 8'd0, data_two: 8'd0,
                     tempo_bpm: (micro_ff == '0) ? QW'(BpmMax) : quo_ff,
                     track_count: total_ff, error_code: ERR_HDR_LEN};
      end
   end

   assign result = res_ff;

endmodule

@@ rtl/midi_file_stream_parser.sv @@
// ============================================================================
// MIDI file stream parser
// Parses a Standard MIDI File byte stream into header, channel, tempo,
// completion and error results.
// ============================================================================
//  channel | ports    | tdata (low bit up)                              | tuser
//  input   | req_*    | stream_byte[7:0]                                | restart
//  result  | rsp_*    | kind, track_index, event_time, message_type,    | -
//          |          | data_one, data_two, tempo_bpm, track_count,     |
//          |          | error_code, zero fill to 120 bits               |
// One byte per cycle while no result waits; a byte that makes a result is
// followed at once only when that result leaves in the same cycle.
// A tempo event's last byte runs the bit-serial divider: the divide and finish
// states run before its result shows, with intake stopped meanwhile.
// reset is synchronous and returns the parser to the header id.
// Backpressure on rsp_tready holds the result and stops byte intake.
module midi_file_stream_parser
   import mfsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // stream_byte
   input  logic         req_tuser,   // restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata    // kind, track_index, event_time, message_type,
                                     // data_one, data_two, tempo_bpm, track_count,
                                     // error_code
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   result_type  res;

   mfsp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd, .stat
   );

   mfsp_datapath u_dp (
      .clock, .reset,
      .stream_byte(req_tdata), .restart(req_tuser),
      .cmd, .stat, .result(res)
   );

   assign rsp_tdata = {5'd0, res.error_code, res.track_count, res.tempo_bpm,
                       res.data_two, res.data_one, res.message_type,
                       res.event_time, res.track_index, res.kind};

endmodule

@@ rtl/mfsp_checker.sv @@
// ============================================================================
// MIDI file stream parser port checker
// Port-level checks, bound to the top level.
// ============================================================================
`include "midi_file_stream_parser_defines.svh"
module mfsp_port_checker
   import mfsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata
);

   logic [2:0] rsp_kind;
   logic [1:0] rsp_err;

   assign rsp_kind = rsp_tdata[2:0];
   assign rsp_err  = rsp_tdata[114:113];

   `MFSP_ASSERT_IMP(a_kind_range, clock, reset, rsp_tvalid, rsp_kind <= KIND_ERROR, "bad kind")
   `MFSP_ASSERT_IMP(a_err_only, clock, reset, rsp_tvalid && rsp_kind != KIND_ERROR, rsp_err == 2'd0, "stray error")
   `MFSP_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `MFSP_ASSERT_IMP(a_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "intake while full")

endmodule

bind midi_file_stream_parser mfsp_port_checker u_chk (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

@@ verif/mfsp_checker.sv @@
// ============================================================================
// MIDI file stream parser checker
// Watches both channels, predicts every result from the accepted bytes, and
// compares each result transfer field by field with the oldest prediction.
// ============================================================================
module mfsp_checker
   import mfsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // stream_byte
   input  logic         req_tuser,   // restart
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,   // kind, track_index, event_time, message_type,
                                     // data_one, data_two, tempo_bpm, track_count,
                                     // error_code
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint LeftFloor = -64'sd4294967296;

   // parser image
   phase_type   ph;
   int unsigned fcnt;
   longint      left;
   bit [15:0]   ntrk, trk;
   bit [31:0]   abs_t, vl, pay;
   bit [7:0]    rs, held, mk;
   bit [23:0]   micro;
   bit [25:0]   bpm;

   result_type  result_q[$];
   int          tempo_seen, chan_seen, err_seen, done_seen;

   assign pending = result_q.size();

   function automatic int data_len(input bit [3:0] nib);
      case (nib)
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 2;
         4'hC, 4'hD:                   return 1;
         default:                      return 0;
      endcase
   endfunction

   function automatic result_type make_result(input logic [2:0] kind, input bit [3:0] mt,
                                              input bit [7:0] d1, input bit [7:0] d2,
                                              input logic [1:0] code);
      result_type r;
      r.kind = kind;          r.track_index = trk;   r.event_time = abs_t;
      r.message_type = mt;    r.data_one = d1;       r.data_two = d2;
      r.tempo_bpm = bpm;      r.track_count = ntrk;  r.error_code = code;
      return r;
   endfunction

   task automatic clear_parser();
      ph = PH_HID; fcnt = 0; left = 0; ntrk = '0; trk = '0; abs_t = '0; vl = '0;
      rs = '0; held = '0; mk = '0; pay = '0; micro = '0; bpm = 26'd120;
   endtask

   task automatic count_down();
      if (left > LeftFloor) left--;
   endtask

   task automatic halt(input logic [1:0] code, inout bit got, inout result_type res);
      ph = PH_HALT;
      got = 1;
      res = make_result(KIND_ERROR, '0, '0, '0, code);
   endtask

   // end of an event: next delta, next track, or completion
   task automatic close_event(inout bit got, inout result_type res);
      if (left > 0) begin
         ph = PH_DELTA;
         vl = '0;
      end else begin
         trk++;
         fcnt = 0;
         if (trk == ntrk) begin
            if (got) begin
               ph = PH_DONEPEND;
            end else begin
               ph = PH_DONE;
               got = 1;
               res = make_result(KIND_DONE, '0, '0, '0, ERR_HDR_LEN);
            end
         end else begin
            ph = PH_TID;
         end
      end
   endtask

   task automatic chan_event(input bit [7:0] d2, inout bit got, inout result_type res);
      got = 1;
      res = make_result(KIND_CHAN, rs[7:4], held, d2, ERR_HDR_LEN);
      close_event(got, res);
   endtask

   task automatic parse_byte(input bit [7:0] b, input bit restart,
                             output bit got, output result_type res);
      int n;
      got = 0;
      res = '0;
      if (restart) clear_parser();
      case (ph)
         PH_HID, PH_TID: begin
            fcnt++;
            if (fcnt >= 4) begin
               fcnt = 0;
               vl = '0;
               ph = (ph == PH_HID) ? PH_HLEN : PH_TLEN;
            end
         end
         PH_HLEN: begin
            vl = {vl[23:0], b};
            fcnt++;
            if (fcnt >= 4) begin
               fcnt = 0;
               ph = PH_HFMT;
            end
         end
         PH_HFMT: begin
            fcnt++;
            if (fcnt >= 2) begin
               fcnt = 0;
               ph = PH_HNTRK;
            end
         end
         PH_HNTRK: begin
            ntrk = {ntrk[7:0], b};
            fcnt++;
            if (fcnt >= 2) begin
               fcnt = 0;
               ph = PH_HDIV;
            end
         end
         PH_HDIV: begin
            fcnt++;
            if (fcnt >= 2) begin
               fcnt = 0;
               if (vl[31]) halt(ERR_HDR_LEN, got, res);
               else if (ntrk == 0) halt(ERR_NO_TRACKS, got, res);
               else begin
                  left = longint'({32'd0, vl}) - 6;
                  ph = (left > 0) ? PH_HSKIP : PH_TID;
                  got = 1;
                  res = make_result(KIND_HEADER, '0, '0, '0, ERR_HDR_LEN);
               end
            end
         end
         PH_HSKIP: begin
            count_down();
            if (left <= 0) begin
               fcnt = 0;
               ph = PH_TID;
            end
         end
         PH_TLEN: begin
            vl = {vl[23:0], b};
            fcnt++;
            if (fcnt >= 4) begin
               fcnt = 0;
               left = longint'({32'd0, vl});
               if (vl[31]) left = left - 64'sd4294967296;
               abs_t = '0;
               rs = '0;
               close_event(got, res);
            end
         end
         PH_DELTA: begin
            count_down();
            vl = (vl << 7) + b[6:0];
            if (!b[7]) begin
               abs_t += vl;
               ph = PH_STATUS;
            end
         end
         PH_STATUS: begin
            count_down();
            if (b[7]) rs = b;
            n = data_len(rs[7:4]);
            if (n == 0) begin
               // sysex, meta, or a status that cannot start an event
               if (rs == STAT_META) ph = PH_MTYPE;
               else if (rs == STAT_SYSEX || rs == STAT_ESC) begin
                  mk = rs;
                  vl = '0;
                  ph = PH_MLEN;
               end else halt(ERR_EVENT, got, res);
            end else if (b[7]) ph = PH_DATA1;
            else begin
               held = b;
               if (n == 2) ph = PH_DATA2;
               else chan_event(8'd0, got, res);
            end
         end
         PH_DATA1: begin
            count_down();
            held = b;
            if (data_len(rs[7:4]) == 2) ph = PH_DATA2;
            else chan_event(8'd0, got, res);
         end
         PH_DATA2: begin
            count_down();
            chan_event(b, got, res);
         end
         PH_MTYPE: begin
            count_down();
            mk = b;
            vl = '0;
            ph = PH_MLEN;
         end
         PH_MLEN: begin
            count_down();
            vl = (vl << 7) + b[6:0];
            if (!b[7]) begin
               if (longint'({32'd0, vl}) > left) halt(ERR_OVERRUN, got, res);
               else if (mk == META_TEMPO) begin
                  fcnt = 0;
                  micro = '0;
                  ph = PH_TEMPO;
               end else begin
                  pay = vl;
                  if (pay > 0) ph = PH_SKIP;
                  else close_event(got, res);
               end
            end
         end
         PH_TEMPO: begin
            count_down();
            micro = {micro[15:0], b};
            fcnt++;
            if (fcnt >= 3) begin
               fcnt = 0;
               bpm = (micro == 0) ? BpmW'(BpmMax) : BpmW'(BpmMax / micro);
               got = 1;
               res = make_result(KIND_TEMPO, '0, '0, '0, ERR_HDR_LEN);
               close_event(got, res);
            end
         end
         PH_SKIP: begin
            count_down();
            pay--;
            if (pay == 0) close_event(got, res);
         end
         PH_DONEPEND: begin
            ph = PH_DONE;
            got = 1;
            res = make_result(KIND_DONE, '0, '0, '0, ERR_HDR_LEN);
         end
         default: ;
      endcase
   endtask

   initial begin
      clear_parser();
      fail_count = 0;
      tempo_seen = 0; chan_seen = 0; err_seen = 0; done_seen = 0;
   end

   // compare result transfers, then predict from byte transfers
   always @(posedge clock) begin
      result_type want, got_r;
      bit         got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_r.kind         = rsp_tdata[2:0];
            got_r.track_index  = rsp_tdata[18:3];
            got_r.event_time   = rsp_tdata[50:19];
            got_r.message_type = rsp_tdata[54:51];
            got_r.data_one     = rsp_tdata[62:55];
            got_r.data_two     = rsp_tdata[70:63];
            got_r.tempo_bpm    = rsp_tdata[96:71];
            got_r.track_count  = rsp_tdata[112:97];
            got_r.error_code   = rsp_tdata[114:113];
            if (result_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected result %p", $realtime, got_r);
            end else begin
               want = result_q.pop_front();
               case (want.kind)
                  KIND_CHAN:  chan_seen++;
                  KIND_TEMPO: tempo_seen++;
                  KIND_DONE:  done_seen++;
                  KIND_ERROR: err_seen++;
                  default: ;
               endcase
               if (got_r.kind != want.kind || got_r.track_index != want.track_index ||
                   got_r.event_time != want.event_time ||
                   got_r.message_type != want.message_type ||
                   got_r.data_one != want.data_one || got_r.data_two != want.data_two ||
                   got_r.tempo_bpm != want.tempo_bpm ||
                   got_r.track_count != want.track_count ||
                   got_r.error_code != want.error_code) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("[%0t] result mismatch", $realtime);
                     $display("   expected %p", want);
                     $display("   actual   %p", got_r);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tuser, got, want);
            if (got) result_q.push_back(want);
         end
      end
   end

endmodule

@@ verif/tb_midi_file_stream_parser.sv @@
// ============================================================================
// MIDI file stream parser testbench
// Feeds directed and random MIDI files (well formed, damaged and noise) with
// random idling, random output stalls and one long output hold-off; the checker predicts and compares.
// ============================================================================
module tb_midi_file_stream_parser;
   import mfsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;     // stream_byte
   logic         req_tuser = 1'b0;   // restart
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;          // result fields, kind in the low bits
   int           fail_count, pending;

   bit           idle_on = 1'b1;
   bit           rx_hold = 1'b0;
   int           cycles, bytes_sent, files_sent;
   bit [7:0]     body_q[$], file_q[$];
   bit [7:0]     gen_status;

   always #2 clock = ~clock;

   midi_file_stream_parser u_top (.*);

   mfsp_checker u_check (.*);

   // receiver: random stalls plus a forced hold-off
   always @(negedge clock)
      rsp_tready <= !rx_hold && !(idle_on && $urandom_range(99) < 6);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("midi_file_stream_parser regression: fail");
         $finish;
      end
   end

   // one byte transfer; called at a falling edge
   task automatic send_byte(input bit [7:0] b, input bit restart);
      while (idle_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // variable-length number in n groups; groups above bit 31 are random
   task automatic put_vlq(input bit [31:0] v, input int n);
      bit [6:0] g;
      for (int i = n - 1; i >= 0; i--) begin
         g = (7 * i < 32) ? 7'(v >> (7 * i)) : 7'($urandom);
         body_q.push_back({(i != 0), g});
      end
   endtask

   task automatic put_bytes(input int n);
      repeat (n) body_q.push_back(8'($urandom));
   endtask

   // one event after its delta: 0 chan, 1 running, 2 sysex, 3 meta, 4 tempo
   task automatic put_event(input int sel);
      int n;
      case (sel)
         1: begin
            // running status reuse; odd when the last status was not a channel one
            body_q.push_back(8'($urandom_range(0, 127)));
            if (gen_status[7:4] inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE})
               put_bytes(1);
         end
         2: begin
            n = $urandom_range(0, 4);
            gen_status = $urandom_range(1) ? STAT_SYSEX : STAT_ESC;
            body_q.push_back(gen_status);
            put_vlq(32'(n), 1);
            put_bytes(n);
         end
         3: begin
            n = $urandom_range(0, 4);
            gen_status = STAT_META;
            body_q.push_back(STAT_META);
            body_q.push_back(8'($urandom_range(0, 80)));
            put_vlq(32'(n), 1);
            put_bytes(n);
         end
         4: begin
            gen_status = STAT_META;
            body_q.push_back(STAT_META);
            body_q.push_back(META_TEMPO);
            body_q.push_back(8'd3);
            if ($urandom_range(7) == 0) repeat (3) body_q.push_back(8'd0);
            else put_bytes(3);
         end
         default: begin
            gen_status = 8'h80 + 8'($urandom_range(0, 111));
            body_q.push_back(gen_status);
            put_bytes((gen_status[7:4] inside {4'hC, 4'hD}) ? 1 : 2);
         end
      endcase
   endtask

   task automatic put_header(input bit [31:0] len, input bit [15:0] ntrk);
      file_q = '{8'h4D, 8'h54, 8'h68, 8'h64};
      for (int i = 3; i >= 0; i--) file_q.push_back(len[8*i +: 8]);
      file_q.push_back(8'd0);
      file_q.push_back(8'($urandom_range(0, 2)));
      file_q.push_back(ntrk[15:8]);
      file_q.push_back(ntrk[7:0]);
      file_q.push_back(8'($urandom));
      file_q.push_back(8'($urandom));
      if (!len[31] && len > 6)
         repeat (len - 6) file_q.push_back(8'($urandom));
   endtask

   // close the body as a track chunk; len_adj shifts the length field
   task automatic put_track(input int len_adj, input bit neg);
      bit [31:0] len;
      len = neg ? 32'hFFFF_FF00 | 32'($urandom) : 32'(body_q.size() + len_adj);
      file_q.push_back(8'h4D); file_q.push_back(8'h54);
      file_q.push_back(8'h72); file_q.push_back(8'h6B);
      for (int i = 3; i >= 0; i--) file_q.push_back(len[8*i +: 8]);
      foreach (body_q[i]) file_q.push_back(body_q[i]);
      body_q.delete();
      gen_status = '0;
   endtask

   task automatic random_body(input int nev);
      for (int i = 0; i < nev; i++) begin
         put_vlq($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 200),
                 $urandom_range(1, 5));
         put_event(i == 0 ? 0 : $urandom_range(0, 4));
      end
   endtask

   // file plus a couple of trailing bytes that should be ignored
   task automatic send_file();
      foreach (file_q[i]) send_byte(file_q[i], i == 0);
      repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
      files_sent++;
   endtask

   task automatic random_file();
      int ntrk, pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         file_q.delete();
         repeat ($urandom_range(10, 30)) file_q.push_back(8'($urandom));
      end else begin
         ntrk = $urandom_range(1, 3);
         put_header($urandom_range(3) == 0 ? $urandom_range(6, 9) : 6, 16'(ntrk));
         for (int t = 0; t < ntrk; t++) begin
            random_body($urandom_range(0, 6));
            put_track(pick < 15 ? $urandom_range(0, 6) - 3 : 0, pick < 8 && t == 0);
         end
         // occasional single damaged byte
         if (pick >= 8 && pick < 15)
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
      end
      send_file();
   endtask

   initial begin
      cycles = 0; bytes_sent = 0; files_sent = 0; gen_status = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // well-formed track: all event kinds, running status, 5-group delta, tempo 0
      put_header(32'd8, 16'd2);
      body_q = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h05, 8'h40, 8'h00, 8'h00, 8'hC5, 8'h7F};
      put_vlq(32'hFFFF_FFFF, 5); put_event(0);
      body_q.push_back(8'h00); put_event(2);
      body_q.push_back(8'h00); put_event(3);
      body_q.push_back(8'h00); body_q.push_back(8'hFF); body_q.push_back(META_TEMPO);
      body_q.push_back(8'h03); body_q.push_back(8'h07); body_q.push_back(8'hA1);
      body_q.push_back(8'h20);
      body_q.push_back(8'h00); body_q.push_back(8'hFF); body_q.push_back(META_TEMPO);
      body_q.push_back(8'h03); repeat (3) body_q.push_back(8'h00);
      body_q.push_back(8'h00); body_q.push_back(8'hE0); body_q.push_back(8'hFF);
      body_q.push_back(8'hFF);
      put_track(0, 1'b0);
      // second track: data byte after meta status continues as meta
      body_q = '{8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h12, 8'h06, 8'h01, 8'h55};
      put_track(0, 1'b0);
      send_file();
      // negative header length, zero tracks
      put_header(32'h8000_0006, 16'd1); send_file();
      put_header(32'd6, 16'd0); send_file();
      // empty and negative tracks, then unexpected status bytes
      put_header(32'd6, 16'd3);
      put_track(0, 1'b0);
      put_track(0, 1'b1);
      body_q = '{8'h00, 8'h10};
      put_track(0, 1'b0);
      send_file();
      put_header(32'd6, 16'd1);
      body_q = '{8'h00, 8'hF1, 8'h00};
      put_track(0, 1'b0);
      send_file();
      // meta length beyond the chunk
      put_header(32'd6, 16'd1);
      body_q = '{8'h00, 8'hFF, 8'h01, 8'h81, 8'h00, 8'h00};
      put_track(0, 1'b0);
      send_file();

      // random files, with one long output hold-off and one full drain
      while (bytes_sent < 700) begin
         if (files_sent == 10)
            fork
               begin
                  rx_hold = 1'b1;
                  repeat (300) @(posedge clock);
                  rx_hold = 1'b0;
               end
            join_none
         if (files_sent == 16) begin
            // sender goes quiet until every result is out
            req_tvalid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         idle_on = !(files_sent >= 20 && files_sent < 28);
         random_file();
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (60) @(posedge clock);
      $display("Sent %0d bytes in %0d files; %0d channel, %0d tempo, %0d done, %0d error results",
               bytes_sent, files_sent, u_check.chan_seen, u_check.tempo_seen,
               u_check.done_seen, u_check.err_seen);
      if (fail_count == 0)
         $display("midi_file_stream_parser regression: pass");
      else
         $display("midi_file_stream_parser regression: fail");
      $finish;
   end

endmodule
